/* sv/mwm_pkg.sv */
// Package for the maze wall map / flood fill block.
// Shared constants, operation and register codes, controller/datapath structs.
// No dependencies.
package mwm_pkg;

    localparam int MAX_SIDE_DEF    = 32;
    localparam int QUEUE_DEPTH_DEF = 1024;

    localparam int OP_W    = 3;
    localparam int COORD_W = 5;
    localparam int CODE_W  = 2;
    localparam int CFG_W   = 6;
    localparam int CIDX_W  = 3;
    localparam int DIST_W  = 11;
    localparam int ENTRY_W = 4;

    localparam logic [OP_W-1:0] OP_WR_WALL = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_CELL = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_WALL = 3'd2;
    localparam logic [OP_W-1:0] OP_FLOOD   = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_DIST = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_COLS = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_ROWS = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GX   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GY   = 3'd3;

    localparam logic [CFG_W-1:0]   COLS_RST = 6'd16;
    localparam logic [CFG_W-1:0]   ROWS_RST = 6'd16;
    localparam logic [COORD_W-1:0] GX_RST   = 5'd8;
    localparam logic [COORD_W-1:0] GY_RST   = 5'd7;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [CODE_W-1:0]  CODE_UNKNOWN = 2'd1;
    localparam logic [CODE_W-1:0]  CODE_UNDEF   = 2'd3;
    localparam logic [ENTRY_W-1:0] ENTRY_RST    = {CODE_UNKNOWN, CODE_UNKNOWN};
    localparam logic [DIST_W-1:0]  DIST_MAX     = 11'd2047;
    localparam logic [DIST_W-1:0]  DIST_START   = 11'd1;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic flood_init;
        logic fclr_step;
        logic wall_rd;
        logic wall_wr;
        logic rd_item;
        logic seed;
        logic pop_rd;
        logic cell_load;
        logic h_load;
        logic nb_rd;
        logic nb_label;
        logic dir_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic            clr_done;
        logic            fclr_done;
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            code_skip;
        logic            dir_last;
        logic            nb_inside;
        logic            nb_pass;
        logic            goal_hit;
        logic            q_empty;
        logic            out_free;
    } t_stat;

endpackage

/* sv/maze_wall_map_flood_fill.sv */
// Top level of the maze wall map with breadth-first flood fill.
// Depends on mwm_pkg, mwm_ctrl, mwm_dpath (which holds the mwm_ram instances).
//
//  channel   dir  handshake                      beat contents
//  s_axis    in   s_axis_tvalid/s_axis_tready    operation in tuser, item fields in tdata
//  m_axis    out  m_axis_tvalid/m_axis_tready    wall_value, distance in tdata
//  cfg       in   i_cfg_valid/o_cfg_ready        register index, write data
//
// After reset a clearing pass over all (MAX_SIDE+1)^2 wall entries fills the maps; no beat is
// taken meanwhile, config writes are. Wall writes read, then rewrite the wall entry.
// A flood first clears the MAX_SIDE^2 distance entries, then pops each queued cell and
// checks its neighbors (registered RAM reads).
// One item at a time; a stalled result waits in the output register, the next beat is
// still taken.
module maze_wall_map_flood_fill import mwm_pkg::*; #(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] cell_x, [9:5] cell_y, [11:10] direction, [13:12] wall_code,
    // [15:14] wall_north, [17:16] wall_east, [19:18] wall_south, [21:20] wall_west,
    // [23:22] pass_threshold, [24] full_flood, [31:25] zero
    input  logic [31:0]       s_axis_tdata,
    input  logic [OP_W-1:0]   s_axis_tuser,   // [2:0] operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [1:0] wall_value, [12:2] distance, [15:13] zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    t_cmd              cmd;
    t_stat             stat;
    logic [CODE_W-1:0] wall_value;
    logic [DIST_W-1:0] distance;

    assign o_cfg_ready = 1'b1;

    mwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mwm_dpath #(
        .MAX_SIDE    (MAX_SIDE),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (s_axis_tuser),
        .i_cell_x         (s_axis_tdata[4:0]),
        .i_cell_y         (s_axis_tdata[9:5]),
        .i_direction      (s_axis_tdata[11:10]),
        .i_wall_code      (s_axis_tdata[13:12]),
        .i_wall_north     (s_axis_tdata[15:14]),
        .i_wall_east      (s_axis_tdata[17:16]),
        .i_wall_south     (s_axis_tdata[19:18]),
        .i_wall_west      (s_axis_tdata[21:20]),
        .i_pass_threshold (s_axis_tdata[23:22]),
        .i_full_flood     (s_axis_tdata[24]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_wall_value     (wall_value),
        .o_distance       (distance),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

    assign m_axis_tdata = {3'b000, distance, wall_value};
endmodule

/* sv/mwm_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/mwm_ctrl.sv */
// Controller state machine for the maze wall map / flood fill block.
// Depends on mwm_pkg (t_cmd, t_stat, operation codes).
module mwm_ctrl import mwm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DISP  = 13'b0000000000100,
        S_WRD   = 13'b0000000001000,
        S_WWR   = 13'b0000000010000,
        S_FCLR  = 13'b0000000100000,
        S_FSEED = 13'b0000001000000,
        S_FPOP  = 13'b0000010000000,
        S_FCELL = 13'b0000100000000,
        S_FHGT  = 13'b0001000000000,
        S_FNRD  = 13'b0010000000000,
        S_FNEV  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_WR_WALL, OP_WR_CELL: begin
                        n_state = i_stat.in_range ? S_WRD : S_DONE;
                    end
                    OP_RD_WALL, OP_RD_DIST: begin
                        o_cmd.rd_item = i_stat.in_range;
                        n_state = S_DONE;
                    end
                    OP_FLOOD: begin
                        o_cmd.flood_init = 1'b1;
                        n_state = S_FCLR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WRD: begin
                o_cmd.wall_rd = 1'b1;
                n_state = S_WWR;
            end
            S_WWR: begin
                o_cmd.wall_wr = !i_stat.code_skip;
                if (i_stat.op == OP_WR_CELL && !i_stat.dir_last) begin
                    o_cmd.dir_next = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FCLR: begin
                o_cmd.fclr_step = 1'b1;
                if (i_stat.fclr_done) n_state = S_FSEED;
            end
            S_FSEED: begin
                if (i_stat.in_range) begin
                    o_cmd.seed = 1'b1;
                    n_state = S_FPOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FPOP: begin
                if (i_stat.q_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_FCELL;
                end
            end
            S_FCELL: begin
                o_cmd.cell_load = 1'b1;
                n_state = S_FHGT;
            end
            S_FHGT: begin
                o_cmd.h_load = 1'b1;
                n_state = S_FNRD;
            end
            S_FNRD: begin
                if (i_stat.nb_inside) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state = S_FNEV;
                end else if (i_stat.dir_last) begin
                    n_state = S_FPOP;
                end else begin
                    o_cmd.dir_next = 1'b1;
                    n_state = S_FNRD;
                end
            end
            S_FNEV: begin
                if (i_stat.nb_pass && i_stat.goal_hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.nb_label = i_stat.nb_pass;
                    if (i_stat.dir_last) begin
                        n_state = S_FPOP;
                    end else begin
                        o_cmd.dir_next = 1'b1;
                        n_state = S_FNRD;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

/* sv/mwm_dpath.sv */
// Datapath: config registers, item registers, wall/distance/queue RAMs, output register.
// Depends on mwm_pkg and mwm_ram.
module mwm_dpath import mwm_pkg::*; #(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CIDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [COORD_W-1:0]    i_cell_x,
    input  logic [COORD_W-1:0]    i_cell_y,
    input  logic [1:0]            i_direction,
    input  logic [CODE_W-1:0]     i_wall_code,
    input  logic [CODE_W-1:0]     i_wall_north,
    input  logic [CODE_W-1:0]     i_wall_east,
    input  logic [CODE_W-1:0]     i_wall_south,
    input  logic [CODE_W-1:0]     i_wall_west,
    input  logic [CODE_W-1:0]     i_pass_threshold,
    input  logic                  i_full_flood,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CODE_W-1:0]     o_wall_value,
    output logic [DIST_W-1:0]     o_distance,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int CW  = $clog2(MAX_SIDE);
    localparam int WD  = (MAX_SIDE + 1) * (MAX_SIDE + 1);
    localparam int WAW = $clog2(WD);
    localparam int DD  = MAX_SIDE * MAX_SIDE;
    localparam int DAW = $clog2(DD);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QW  = 2 * CW;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CLW = (SW > CFG_W) ? SW : CFG_W;
    localparam int GW  = (SW > COORD_W) ? SW : COORD_W;

    logic [CFG_W-1:0]   r_cols, r_rows;
    logic [COORD_W-1:0] r_gx, r_gy;

    logic [OP_W-1:0]   r_op;
    logic [CODE_W-1:0] r_wcode, r_wn, r_we, r_ws, r_ww, r_thr;
    logic              r_full, r_inside;
    logic [1:0]        r_dir;
    logic [SW-1:0]     r_cx, r_cy;
    logic [DIST_W-1:0] r_h;
    logic [WAW-1:0]    r_clr;
    logic [QAW-1:0]    r_head, r_tail;
    logic [FW-1:0]     r_fill;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_wall;
    logic [DIST_W-1:0] r_out_dist;

    logic [CLW-1:0]    cols_w, rows_w;
    logic [SW-1:0]     cols_c, rows_c;
    logic [SW-1:0]     lx, ly, nx, ny;
    logic              lsh;
    logic [WAW-1:0]    wall_addr;
    logic [CODE_W-1:0] wall_field, sel_code;
    logic [ENTRY_W-1:0] wall_rdata, wall_wdata, wall_new;
    logic [WAW-1:0]    wall_waddr;
    logic              wall_we, wall_re;
    logic [DIST_W-1:0] dist_rdata, dist_wdata, h_inc;
    logic [DAW-1:0]    dist_waddr, dist_raddr;
    logic              dist_we, dist_re;
    logic [QW-1:0]     q_rdata, q_wdata;
    logic              q_we, q_room;
    logic [SW-1:0]     q_x, q_y;

    function automatic logic [DAW-1:0] didx(input logic [SW-1:0] x, input logic [SW-1:0] y,
                                            input logic [SW-1:0] cols);
        didx = DAW'(x) + DAW'(y) * DAW'(cols);
    endfunction

    // side clamp to 1..MAX_SIDE
    always_comb begin
        cols_w = CLW'(r_cols);
        rows_w = CLW'(r_rows);
        if (cols_w == '0) cols_w = CLW'(1);
        else if (cols_w > CLW'(MAX_SIDE)) cols_w = CLW'(MAX_SIDE);
        if (rows_w == '0) rows_w = CLW'(1);
        else if (rows_w > CLW'(MAX_SIDE)) rows_w = CLW'(MAX_SIDE);
        cols_c = SW'(cols_w);
        rows_c = SW'(rows_w);
    end

    // wall side of current cell -> entry and code position
    always_comb begin
        case (r_dir)
            DIR_NORTH: begin lx = r_cx;          ly = r_cy + SW'(1); end
            DIR_EAST:  begin lx = r_cx + SW'(1); ly = r_cy;          end
            default:   begin lx = r_cx;          ly = r_cy;          end
        endcase
        lsh = (r_dir == DIR_EAST) || (r_dir == DIR_WEST);
        wall_addr = WAW'(lx) + WAW'(ly) * (WAW'(cols_c) + WAW'(1));
    end

    always_comb begin
        case (r_dir)
            DIR_NORTH: begin nx = r_cx;          ny = r_cy + SW'(1); end
            DIR_EAST:  begin nx = r_cx + SW'(1); ny = r_cy;          end
            DIR_SOUTH: begin nx = r_cx;          ny = r_cy - SW'(1); end
            default:   begin nx = r_cx - SW'(1); ny = r_cy;          end
        endcase
    end

    always_comb begin
        case (r_dir)
            DIR_NORTH: sel_code = r_wn;
            DIR_EAST:  sel_code = r_we;
            DIR_SOUTH: sel_code = r_ws;
            default:   sel_code = r_ww;
        endcase
        if (r_op == OP_WR_WALL) sel_code = r_wcode;
    end

    assign wall_field = lsh ? wall_rdata[3:2] : wall_rdata[1:0];
    assign wall_new   = lsh ? {sel_code, wall_rdata[1:0]} : {wall_rdata[3:2], sel_code};
    assign h_inc      = (r_h == DIST_MAX) ? DIST_MAX : r_h + DIST_W'(1);
    assign q_x        = SW'(q_rdata[CW-1:0]);
    assign q_y        = SW'(q_rdata[QW-1:CW]);
    assign q_room     = r_fill < FW'(QUEUE_DEPTH);

    // wall RAM ports
    assign wall_re    = i_cmd.wall_rd | i_cmd.rd_item | i_cmd.nb_rd;
    assign wall_we    = i_cmd.clr_step | i_cmd.wall_wr;
    assign wall_waddr = i_cmd.clr_step ? r_clr : wall_addr;
    assign wall_wdata = i_cmd.clr_step ? ENTRY_RST : wall_new;

    // distance RAM ports
    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = DAW'(r_clr);
        dist_wdata = '0;
        if (i_cmd.clr_step) begin
            dist_we = (r_clr < WAW'(DD));
        end else if (i_cmd.fclr_step) begin
            dist_we = 1'b1;
        end else if (i_cmd.seed) begin
            dist_we    = 1'b1;
            dist_waddr = didx(r_cx, r_cy, cols_c);
            dist_wdata = DIST_START;
        end else if (i_cmd.nb_label) begin
            dist_we    = 1'b1;
            dist_waddr = didx(nx, ny, cols_c);
            dist_wdata = h_inc;
        end
    end

    assign dist_re = i_cmd.rd_item | i_cmd.cell_load | i_cmd.nb_rd;
    always_comb begin
        if (i_cmd.cell_load) dist_raddr = didx(q_x, q_y, cols_c);
        else if (i_cmd.nb_rd) dist_raddr = didx(nx, ny, cols_c);
        else dist_raddr = didx(r_cx, r_cy, cols_c);
    end

    // queue RAM
    assign q_we    = i_cmd.seed | (i_cmd.nb_label & q_room);
    assign q_wdata = i_cmd.seed ? {CW'(r_cy), CW'(r_cx)} : {CW'(ny), CW'(nx)};

    mwm_ram #(.WIDTH(ENTRY_W), .DEPTH(WD)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (wall_we),
        .i_waddr (wall_waddr),
        .i_wdata (wall_wdata),
        .i_re    (wall_re),
        .i_raddr (wall_addr),
        .o_rdata (wall_rdata)
    );

    mwm_ram #(.WIDTH(DIST_W), .DEPTH(DD)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (dist_re),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    mwm_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wdata),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
            r_gx   <= GX_RST;
            r_gy   <= GY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_GX:   r_gx   <= i_cfg_data[COORD_W-1:0];
                CFG_GY:   r_gy   <= i_cfg_data[COORD_W-1:0];
                default:  ;
            endcase
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_op;
            r_wcode  <= i_wall_code;
            r_wn     <= i_wall_north;
            r_we     <= i_wall_east;
            r_ws     <= i_wall_south;
            r_ww     <= i_wall_west;
            r_thr    <= i_pass_threshold;
            r_full   <= i_full_flood;
            r_inside <= (CLW'(i_cell_x) < cols_w) && (CLW'(i_cell_y) < rows_w);
            r_cx     <= SW'(i_cell_x);
            r_cy     <= SW'(i_cell_y);
        end else if (i_cmd.cell_load) begin
            r_cx <= q_x;
            r_cy <= q_y;
        end
        if (i_cmd.h_load) r_h <= dist_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= '0;
        end else if (i_cmd.load_item) begin
            r_dir <= (i_op == OP_WR_WALL || i_op == OP_RD_WALL) ? i_direction : DIR_NORTH;
        end else if (i_cmd.cell_load) begin
            r_dir <= DIR_NORTH;
        end else if (i_cmd.dir_next) begin
            r_dir <= r_dir + 2'd1;
        end
    end

    // sweep counter and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.flood_init) r_clr <= '0;
            else if (i_cmd.clr_step || i_cmd.fclr_step) r_clr <= r_clr + WAW'(1);
            if (i_cmd.flood_init) begin
                r_head <= '0;
                r_tail <= '0;
                r_fill <= '0;
            end else if (q_we) begin
                r_tail <= (r_tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QAW'(1);
                r_fill <= r_fill + FW'(1);
            end else if (i_cmd.pop_rd) begin
                r_head <= (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QAW'(1);
                r_fill <= r_fill - FW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_wall <= (r_op == OP_RD_WALL && r_inside) ? wall_field : '0;
            r_out_dist <= (r_op == OP_RD_DIST && r_inside) ? dist_rdata : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wall_value = r_out_wall;
    assign o_distance   = r_out_dist;

    always_comb begin
        o_stat.clr_done  = (r_clr == WAW'(WD - 1));
        o_stat.fclr_done = (r_clr == WAW'(DD - 1));
        o_stat.op        = r_op;
        o_stat.in_range  = r_inside;
        o_stat.code_skip = (sel_code == CODE_UNDEF);
        o_stat.dir_last  = (r_dir == DIR_WEST);
        case (r_dir)
            DIR_NORTH: o_stat.nb_inside = (r_cy + SW'(1)) < rows_c;
            DIR_EAST:  o_stat.nb_inside = (r_cx + SW'(1)) < cols_c;
            DIR_SOUTH: o_stat.nb_inside = (r_cy != '0);
            default:   o_stat.nb_inside = (r_cx != '0);
        endcase
        o_stat.nb_pass   = (wall_field >= r_thr) && (dist_rdata == '0);
        o_stat.goal_hit  = !r_full && (GW'(nx) == GW'(r_gx)) && (GW'(ny) == GW'(r_gy));
        o_stat.q_empty   = (r_fill == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end
endmodule

/* sim/mwm_checker.sv */
// Checker for maze_wall_map_flood_fill: mirrors the wall map, the distance map and the
// flood search, predicts each result beat and compares it. Depends on mwm_pkg.
`timescale 1ns / 100ps
module mwm_checker import mwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,
    input  logic [OP_W-1:0]   s_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [15:0]       m_axis_tdata,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    localparam int SIDE  = MAX_SIDE_DEF;
    localparam int WCELL = (SIDE + 1) * (SIDE + 1);
    localparam int DCELL = SIDE * SIDE;

    typedef struct packed {
        logic [CODE_W-1:0] wall;
        logic [DIST_W-1:0] dist_val;
    } t_reply;

    logic [ENTRY_W-1:0] walls [WCELL];
    logic [DIST_W-1:0]  dists [DCELL];
    logic [CFG_W-1:0]   cols_r, rows_r;
    logic [COORD_W-1:0] goal_x_r, goal_y_r;
    t_reply             replies_due [$];

    function automatic int side_of(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > SIDE) return SIDE;
        return int'(v);
    endfunction

    function automatic int wall_slot(int x, int y);
        int i;
        i = x + y * (side_of(cols_r) + 1);
        return (i < WCELL) ? i : 0;
    endfunction

    function automatic int dist_slot(int x, int y);
        int i;
        i = x + y * side_of(cols_r);
        return (i < DCELL) ? i : 0;
    endfunction

    function automatic void locate(int x, int y, logic [1:0] dir, output int idx, output int sh);
        case (dir)
            DIR_NORTH: begin idx = wall_slot(x, y + 1); sh = 0; end
            DIR_EAST:  begin idx = wall_slot(x + 1, y); sh = 2; end
            DIR_SOUTH: begin idx = wall_slot(x, y); sh = 0; end
            default:   begin idx = wall_slot(x, y); sh = 2; end
        endcase
    endfunction

    function automatic logic [1:0] wall_code_at(int x, int y, logic [1:0] dir);
        int idx, sh;
        locate(x, y, dir, idx, sh);
        return walls[idx][sh +: 2];
    endfunction

    function automatic void set_wall(int x, int y, logic [1:0] dir, logic [1:0] code);
        int idx, sh;
        if (code == CODE_UNDEF) return;
        locate(x, y, dir, idx, sh);
        walls[idx][sh +: 2] = code;
    endfunction

    function automatic void run_flood(int sx, int sy, logic [1:0] thr, logic full);
        int cols, rows, x, y, nx, ny, ni, c;
        logic [DIST_W-1:0] h;
        int cells [$];
        cols = side_of(cols_r);
        rows = side_of(rows_r);
        for (int i = 0; i < DCELL; i++) dists[i] = '0;
        if (sx >= cols || sy >= rows) return;
        dists[dist_slot(sx, sy)] = DIST_START;
        cells.push_back(sx + sy * SIDE);
        while (cells.size() > 0) begin
            c = cells.pop_front();
            x = c % SIDE;
            y = c / SIDE;
            h = dists[dist_slot(x, y)];
            for (int d = 0; d < 4; d++) begin
                nx = x; ny = y;
                case (d)
                    0: ny++;
                    1: nx++;
                    2: ny--;
                    default: nx--;
                endcase
                if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                ni = dist_slot(nx, ny);
                if (wall_code_at(x, y, 2'(d)) >= thr && dists[ni] == 0) begin
                    if (!full && nx == goal_x_r && ny == goal_y_r) return;
                    dists[ni] = (h == DIST_MAX) ? DIST_MAX : h + 1'b1;
                    if (cells.size() < QUEUE_DEPTH_DEF) cells.push_back(nx + ny * SIDE);
                end
            end
        end
    endfunction

    function automatic t_reply predict(logic [OP_W-1:0] op, logic [31:0] d);
        t_reply r;
        int x, y;
        logic in_range;
        r = '0;
        x = d[4:0];
        y = d[9:5];
        in_range = (x < side_of(cols_r)) && (y < side_of(rows_r));
        case (op)
            OP_WR_WALL: if (in_range) set_wall(x, y, d[11:10], d[13:12]);
            OP_WR_CELL: if (in_range) begin
                set_wall(x, y, DIR_NORTH, d[15:14]);
                set_wall(x, y, DIR_EAST,  d[17:16]);
                set_wall(x, y, DIR_SOUTH, d[19:18]);
                set_wall(x, y, DIR_WEST,  d[21:20]);
            end
            OP_RD_WALL: if (in_range) r.wall = wall_code_at(x, y, d[11:10]);
            OP_FLOOD:   run_flood(x, y, d[23:22], d[24]);
            OP_RD_DIST: if (in_range) r.dist_val = dists[dist_slot(x, y)];
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        int bad;
        if (!i_rst_n) begin
            for (int i = 0; i < WCELL; i++) walls[i] = ENTRY_RST;
            for (int i = 0; i < DCELL; i++) dists[i] = '0;
            cols_r   = COLS_RST;
            rows_r   = ROWS_RST;
            goal_x_r = GX_RST;
            goal_y_r = GY_RST;
            replies_due.delete();
            o_errors  <= 0;
        end else begin
            bad = 0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLS: cols_r   = i_cfg_data;
                    CFG_ROWS: rows_r   = i_cfg_data;
                    CFG_GX:   goal_x_r = i_cfg_data[COORD_W-1:0];
                    CFG_GY:   goal_y_r = i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    bad++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_axis_tdata[1:0] !== want.wall) begin
                        $display("%0t: wall_value expected %0d got %0d",
                                 $time, want.wall, m_axis_tdata[1:0]);
                        bad++;
                    end
                    if (m_axis_tdata[12:2] !== want.dist_val) begin
                        $display("%0t: distance expected %0d got %0d",
                                 $time, want.dist_val, m_axis_tdata[12:2]);
                        bad++;
                    end
                    if (m_axis_tdata[15:13] !== 3'b000) begin
                        $display("%0t: pad bits expected 0 got %b", $time, m_axis_tdata[15:13]);
                        bad++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(predict(s_axis_tuser, s_axis_tdata));
            o_errors <= o_errors + bad;
        end
        o_pending <= replies_due.size();
    end
endmodule

/* sim/tb_maze_wall_map_flood_fill.sv */
// Testbench top for maze_wall_map_flood_fill: drives item and register beats, random
// idling and one long output hold-off. Depends on mwm_pkg and mwm_checker.
`timescale 1ns / 100ps
module tb_maze_wall_map_flood_fill;
    import mwm_pkg::*;

    localparam logic [1:0] CODE_WALL = 2'd0;
    localparam logic [1:0] CODE_OPEN = 2'd2;

    localparam logic [OP_W-1:0]   OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_HI  = 3'd7;
    localparam logic [CIDX_W-1:0] CFG_SPARE    = 3'd5;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [OP_W-1:0]   s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    int                errors, pending;
    int                beats_in = 0;
    int                cols_now = 16, rows_now = 16;
    logic              calm;

    always #10 i_clk = ~i_clk;

    assign calm = (beats_in >= 150 && beats_in < 230);

    maze_wall_map_flood_fill dut (.*);

    mwm_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    function automatic logic [31:0] pack_item(int x, int y, logic [1:0] dir, logic [1:0] code,
                                              logic [7:0] cell_codes, logic [1:0] thr,
                                              logic full);
        return {7'd0, full, thr, cell_codes, code, dir, 5'(y), 5'(x)};
    endfunction

    task automatic send(logic [OP_W-1:0] op, logic [31:0] d);
        if (!calm && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_in++;
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_COLS) cols_now = (val < 1) ? 1 : (val > 32) ? 32 : val;
        if (idx == CFG_ROWS) rows_now = (val < 1) ? 1 : (val > 32) ? 32 : val;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [1:0] biased_code();
        return ($urandom_range(99) < 55) ? CODE_OPEN : 2'($urandom_range(3));
    endfunction

    task automatic random_items(int count);
        int x, y, r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                x = $urandom_range(31);
                y = $urandom_range(31);
            end else begin
                x = $urandom_range(cols_now - 1);
                y = $urandom_range(rows_now - 1);
            end
            if (r < 30)      op = OP_WR_WALL;
            else if (r < 45) op = OP_WR_CELL;
            else if (r < 55) op = OP_RD_WALL;
            else if (r < 64) op = OP_FLOOD;
            else if (r < 96) op = OP_RD_DIST;
            else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            send(op, pack_item(x, y, 2'($urandom_range(3)), biased_code(),
                               {biased_code(), biased_code(), biased_code(), biased_code()},
                               ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : CODE_OPEN,
                               1'($urandom_range(1))));
        end
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (!held && beats_in >= 40) begin
                held = 1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset geometry 16x16 with goal (8,7)
        send(OP_WR_WALL, pack_item(0, 0, DIR_NORTH, CODE_OPEN, 8'h00, 0, 0));
        send(OP_WR_WALL, pack_item(0, 0, DIR_EAST, CODE_WALL, 8'h00, 0, 0));
        send(OP_WR_WALL, pack_item(15, 15, DIR_SOUTH, CODE_OPEN, 8'h00, 0, 0));
        send(OP_WR_WALL, pack_item(15, 15, DIR_WEST, CODE_UNDEF, 8'h00, 0, 0));
        send(OP_WR_CELL, pack_item(3, 4, 0, 0, {CODE_UNDEF, CODE_WALL, CODE_OPEN, CODE_WALL},
                                   0, 0));
        send(OP_WR_WALL, pack_item(31, 31, DIR_NORTH, CODE_WALL, 8'hff, 3, 1));
        send(OP_RD_WALL, pack_item(0, 0, DIR_NORTH, 0, 8'h00, 0, 0));
        send(OP_RD_WALL, pack_item(0, 0, DIR_EAST, 0, 8'h00, 0, 0));
        send(OP_RD_WALL, pack_item(15, 15, DIR_SOUTH, 0, 8'h00, 0, 0));
        send(OP_RD_WALL, pack_item(15, 15, DIR_WEST, 0, 8'h00, 0, 0));
        send(OP_RD_WALL, pack_item(3, 4, DIR_WEST, 0, 8'h00, 0, 0));
        send(OP_RD_WALL, pack_item(20, 2, DIR_NORTH, 0, 8'h00, 0, 0));
        send(OP_FLOOD,   pack_item(0, 0, 0, 0, 8'h00, CODE_WALL, 1'b0));
        send(OP_RD_DIST, pack_item(8, 7, 0, 0, 8'h00, 0, 0));
        send(OP_RD_DIST, pack_item(15, 15, 0, 0, 8'h00, 0, 0));
        send(OP_FLOOD,   pack_item(2, 2, 0, 0, 8'h00, CODE_WALL, 1'b1));
        send(OP_RD_DIST, pack_item(8, 7, 0, 0, 8'h00, 0, 0));
        send(OP_FLOOD,   pack_item(5, 5, 0, 0, 8'h00, CODE_UNDEF, 1'b1));
        send(OP_RD_DIST, pack_item(5, 5, 0, 0, 8'h00, 0, 0));
        send(OP_RD_DIST, pack_item(5, 6, 0, 0, 8'h00, 0, 0));
        send(OP_FLOOD,   pack_item(31, 0, 0, 0, 8'h00, 0, 1'b1));
        send(OP_RD_DIST, pack_item(31, 31, 0, 0, 8'h00, 0, 0));
        send(OP_SPARE_LO,  32'h01ff_ffff);
        send(OP_SPARE_MID, 32'h0155_5555);
        send(OP_SPARE_HI,  32'h00aa_aaaa);
        random_items(60);
        drain();

        write_reg(CFG_COLS, 6'd4);  write_reg(CFG_ROWS, 6'd4);
        write_reg(CFG_GX, 6'd3);    write_reg(CFG_GY, 6'd3);
        random_items(60);
        drain();

        write_reg(CFG_COLS, 6'd1);  write_reg(CFG_ROWS, 6'd1);
        write_reg(CFG_GX, 6'd0);    write_reg(CFG_GY, 6'd0);
        write_reg(CFG_SPARE, 6'd63);
        random_items(30);
        drain();

        write_reg(CFG_COLS, 6'd0);  write_reg(CFG_ROWS, 6'd63);
        write_reg(CFG_GX, 6'd31);   write_reg(CFG_GY, 6'd31);
        random_items(50);
        drain();

        write_reg(CFG_COLS, 6'd32); write_reg(CFG_ROWS, 6'd32);
        write_reg(CFG_GX, 6'd31);   write_reg(CFG_GY, 6'd0);
        random_items(80);
        drain();

        write_reg(CFG_COLS, 6'd63); write_reg(CFG_ROWS, 6'd0);
        write_reg(CFG_GX, 6'd0);    write_reg(CFG_GY, 6'd0);
        random_items(50);
        drain();

        write_reg(CFG_COLS, 6'd6);  write_reg(CFG_ROWS, 6'd5);
        write_reg(CFG_GX, 6'd9);    write_reg(CFG_GY, 6'd2);
        random_items(50);
        drain();

        write_reg(CFG_COLS, 6'd8);  write_reg(CFG_ROWS, 6'd7);
        write_reg(CFG_GX, 6'd5);    write_reg(CFG_GY, 6'd4);
        random_items(55);
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/mwm_pkg.sv
sv/mwm_ram.sv
sv/mwm_ctrl.sv
sv/mwm_dpath.sv
sv/maze_wall_map_flood_fill.sv
sim/mwm_checker.sv
sim/tb_maze_wall_map_flood_fill.sv
